### rtl/core/hpr_pkg.sv
// ----------------------------------------------------------------------------
// hpr_pkg
// Shared types, constants and a helper function for the HSV pixel recolor block.
// ----------------------------------------------------------------------------
package hpr_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_GAIN   = 3'd4;
    localparam int CFG_DATA_W = 24;

    // Fixed point constants: hue is degrees * 128, S and V are Q16.
    localparam logic [15:0] HUE_SIXTH   = 16'd7680;
    localparam logic [15:0] HUE_THIRD   = 16'd15360;
    localparam logic [17:0] HUE_FULL    = 18'd46080;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    // ceil(2^25 / 15), exact for dividends below 2^21.
    localparam logic [21:0] RECIP15     = 22'd2236963;

    // Pipeline organization.
    localparam int NUM_W        = 24;
    localparam int DIV_PER_STG  = 4;
    localparam int DIV_STAGES   = NUM_W / DIV_PER_STG;
    localparam int CONV_STAGES  = DIV_STAGES + 3;
    localparam int BACK_STAGES  = 5;
    localparam int N_STAGES     = CONV_STAGES + BACK_STAGES;

    typedef enum logic [2:0] {
        SEC_RY,
        SEC_YG,
        SEC_GC,
        SEC_CB,
        SEC_BM,
        SEC_MR
    } hue_sector_t;

    // Partial state of a restoring divider by an 8-bit divisor.
    typedef struct packed {
        logic [7:0]       rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
    } div_st_t;

    function automatic div_st_t div_step(div_st_t st, logic [7:0] dvs);
        div_st_t    r;
        logic [8:0] trial;
        r = st;
        for (int i = 0; i < DIV_PER_STG; i++)
        begin
            trial = {r.rem, r.num[NUM_W-1]};
            r.num = {r.num[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs})
            begin
                r.rem = 8'(trial - {1'b0, dvs});
                r.quo = {r.quo[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r.rem = trial[7:0];
                r.quo = {r.quo[NUM_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/hpr_hsv_conv.sv
// ----------------------------------------------------------------------------
// hpr_hsv_conv
// Pipelined RGB to HSV conversion with two restoring dividers.
// ----------------------------------------------------------------------------
module hpr_hsv_conv (
    input  logic                            clk,
    input  logic [hpr_pkg::CONV_STAGES-1:0] en,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    output logic [15:0]                     hue,
    output logic [16:0]                     sat,
    output logic [16:0]                     val
);
    import hpr_pkg::*;

    logic [7:0] r_reg, g_reg, b_reg;

    logic [7:0]  mx, mn, d;
    logic [10:0] hsum;
    logic [23:0] num_s, num_h;

    div_st_t    ds_reg [DIV_STAGES+1];
    div_st_t    dh_reg [DIV_STAGES+1];
    logic [7:0] mx_reg [DIV_STAGES+1];
    logic [7:0] d_reg  [DIV_STAGES+1];
    logic       gray_reg [DIV_STAGES+1];

    logic [15:0] hq;
    logic [15:0] hue_reg;
    logic [16:0] sat_reg, val_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg <= red;
            g_reg <= green;
            b_reg <= blue;
        end
    end

    always_comb
    begin
        mx = r_reg;
        mn = r_reg;
        if (g_reg > mx) mx = g_reg;
        if (b_reg > mx) mx = b_reg;
        if (g_reg < mn) mn = g_reg;
        if (b_reg < mn) mn = b_reg;
        d = mx - mn;
        // Blue wins ties over green, and green over red.
        if (b_reg == mx)
            hsum = 11'({d, 2'b00}) + 11'(r_reg) - 11'(g_reg);
        else if (g_reg == mx)
            hsum = 11'({d, 1'b0}) + 11'(b_reg) - 11'(r_reg);
        else if (g_reg >= b_reg)
            hsum = 11'(g_reg) - 11'(b_reg);
        else
            hsum = 11'(d) * 11'd6 + 11'(g_reg) - 11'(b_reg);
        num_s = {d, 16'h0000} + 24'(mx[7:1]);
        num_h = 24'(hsum) * 24'(HUE_SIXTH);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ds_reg[0]   <= '{rem: '0, num: num_s, quo: '0};
            dh_reg[0]   <= '{rem: '0, num: num_h, quo: '0};
            mx_reg[0]   <= mx;
            d_reg[0]    <= d;
            gray_reg[0] <= (d == 8'd0);
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en[k+1])
            begin
                ds_reg[k]   <= div_step(ds_reg[k-1], mx_reg[k-1]);
                dh_reg[k]   <= div_step(dh_reg[k-1], d_reg[k-1]);
                mx_reg[k]   <= mx_reg[k-1];
                d_reg[k]    <= d_reg[k-1];
                gray_reg[k] <= gray_reg[k-1];
            end
        end
    end

    assign hq = dh_reg[DIV_STAGES].quo[15:0];

    always_ff @(posedge clk)
    begin
        if (en[CONV_STAGES-1])
        begin
            if (gray_reg[DIV_STAGES])
            begin
                hue_reg <= '0;
                sat_reg <= '0;
            end
            else
            begin
                hue_reg <= (18'(hq) >= HUE_FULL) ? 16'(18'(hq) - HUE_FULL) : hq;
                sat_reg <= ds_reg[DIV_STAGES].quo[16:0];
            end
            // ceil(mx * 65536 / 255) equals mx * 257 plus one for any nonzero mx.
            val_reg <= 17'(mx_reg[DIV_STAGES]) * 17'd257
                       + 17'(mx_reg[DIV_STAGES] != 8'd0);
        end
    end

    assign hue = hue_reg;
    assign sat = sat_reg;
    assign val = val_reg;

endmodule

### rtl/core/hpr_hsv_back.sv
// ----------------------------------------------------------------------------
// hpr_hsv_back
// Hue shift or saturation/value scaling, then pipelined HSV to RGB conversion.
// ----------------------------------------------------------------------------
module hpr_hsv_back (
    input  logic                            clk,
    input  logic [hpr_pkg::BACK_STAGES-1:0] en,
    input  logic                            mode,
    input  logic [15:0]                     saturation_gain,
    input  logic [15:0]                     value_gain,
    input  logic [15:0]                     target_hue,
    input  logic [15:0]                     reference_hue,
    input  logic [15:0]                     hue,
    input  logic [16:0]                     sat,
    input  logic [16:0]                     val,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue
);
    import hpr_pkg::*;

    // Stage 0: hue shift or gains.
    logic [17:0] hs;
    logic [32:0] ps, pv;
    logic [15:0] h0_next;
    logic [16:0] s0_next, v0_next;
    logic [15:0] h0_reg;
    logic [16:0] s0_reg, v0_reg;

    always_comb
    begin
        hs = 18'(target_hue) + 18'(reference_hue) + 18'd92160 - 18'(hue);
        ps = 33'(sat) * 33'(saturation_gain);
        pv = 33'(val) * 33'(value_gain);
        h0_next = hue;
        s0_next = sat;
        v0_next = val;
        if (!mode)
        begin
            if (hs >= 18'd138240)
                h0_next = 16'(hs - 18'd138240);
            else if (hs >= 18'd92160)
                h0_next = 16'(hs - 18'd92160);
            else if (hs >= HUE_FULL)
                h0_next = 16'(hs - HUE_FULL);
            else
                h0_next = hs[15:0];
        end
        else
        begin
            s0_next = (ps[32:8] > 25'(ONE_Q16)) ? ONE_Q16 : ps[24:8];
            v0_next = (pv[32:8] > 25'(ONE_Q16)) ? ONE_Q16 : pv[24:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            h0_reg <= h0_next;
            s0_reg <= s0_next;
            v0_reg <= v0_next;
        end
    end

    // Stage 1: chroma, sector and triangle weight.
    logic [33:0]  cv;
    logic [16:0]  c1_next;
    logic [13:0]  t;
    logic [12:0]  hue_dist;
    hue_sector_t  sec1_next;
    logic [16:0]  c1_reg, m1_reg;
    logic [12:0]  w1_reg;
    hue_sector_t  sec1_reg;

    always_comb
    begin
        cv = 34'(s0_reg) * 34'(v0_reg);
        c1_next = cv[32:16];
        if (h0_reg >= 16'd30720)
            t = 14'(h0_reg - 16'd30720);
        else if (h0_reg >= HUE_THIRD)
            t = 14'(h0_reg - HUE_THIRD);
        else
            t = h0_reg[13:0];
        if (t >= 14'(HUE_SIXTH))
            hue_dist = 13'(t - 14'(HUE_SIXTH));
        else
            hue_dist = 13'(14'(HUE_SIXTH) - t);
        if (h0_reg >= 16'd38400)
            sec1_next = SEC_MR;
        else if (h0_reg >= 16'd30720)
            sec1_next = SEC_BM;
        else if (h0_reg >= 16'd23040)
            sec1_next = SEC_CB;
        else if (h0_reg >= HUE_THIRD)
            sec1_next = SEC_GC;
        else if (h0_reg >= HUE_SIXTH)
            sec1_next = SEC_YG;
        else
            sec1_next = SEC_RY;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            c1_reg   <= c1_next;
            m1_reg   <= v0_reg - c1_next;
            w1_reg   <= 13'(HUE_SIXTH) - hue_dist;
            sec1_reg <= sec1_next;
        end
    end

    // Stage 2: C times the triangle weight.
    logic [29:0]  p2_reg;
    logic [16:0]  c2_reg, m2_reg;
    hue_sector_t  sec2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p2_reg   <= 30'(c1_reg) * 30'(w1_reg);
            c2_reg   <= c1_reg;
            m2_reg   <= m1_reg;
            sec2_reg <= sec1_reg;
        end
    end

    // Stage 3: divide by 7680 as a shift by 9 and a reciprocal multiply by 15.
    logic [42:0]  xq;
    logic [16:0]  x3_reg, c3_reg, m3_reg;
    hue_sector_t  sec3_reg;

    assign xq = 43'(p2_reg[29:9]) * 43'(RECIP15);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            x3_reg   <= xq[41:25];
            c3_reg   <= c2_reg;
            m3_reg   <= m2_reg;
            sec3_reg <= sec2_reg;
        end
    end

    // Stage 4: sector mapping and scaling to 8 bits.
    logic [16:0] pr, pg, pb;

    function automatic logic [7:0] chan_out(logic [16:0] p, logic [16:0] m);
        logic [16:0] sum;
        logic [24:0] scaled;
        sum    = p + m;
        scaled = {sum, 8'h00} - 25'(sum);
        return (scaled[24:16] > 9'd255) ? 8'd255 : scaled[23:16];
    endfunction

    always_comb
    begin
        pr = '0;
        pg = '0;
        pb = '0;
        case (sec3_reg)
            SEC_RY:
            begin
                pr = c3_reg;
                pg = x3_reg;
            end
            SEC_YG:
            begin
                pr = x3_reg;
                pg = c3_reg;
            end
            SEC_GC:
            begin
                pg = c3_reg;
                pb = x3_reg;
            end
            SEC_CB:
            begin
                pg = x3_reg;
                pb = c3_reg;
            end
            SEC_BM:
            begin
                pr = x3_reg;
                pb = c3_reg;
            end
            default:
            begin
                pr = c3_reg;
                pb = x3_reg;
            end
        endcase
    end

    logic [7:0] r_reg, g_reg, b_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            r_reg <= chan_out(pr, m3_reg);
            g_reg <= chan_out(pg, m3_reg);
            b_reg <= chan_out(pb, m3_reg);
        end
    end

    assign red   = r_reg;
    assign green = g_reg;
    assign blue  = b_reg;

endmodule

### rtl/core/hsv_pixel_recolor.sv
// ----------------------------------------------------------------------------
// hsv_pixel_recolor
// Per-pixel RGBA recolor by hue shift or saturation/value scaling.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel and leave on the m_axis channel, one
// result transfer for every input transfer, in order. The cfg port writes
// the mode, the target and reference colors and the two 8.8 gains; it must be
// written only while no pixel is in flight, which the block does not enforce.
// The datapath is a 14 stage pipeline: an input register, one stage for the
// min/max and dividend setup, six divider stages (four quotient bits each,
// which set the depth), one stage to finish HSV, then hue shift or gains,
// chroma, the triangle multiply, the divide by 7680 and the output register.
// A pixel's result is presented on m_axis from the output register, and one
// pixel is accepted every cycle while the receiver holds m_axis_tready high.
// The target and reference hues run through their own converters in lockstep
// with the pixel.
// Reset clears all valid bits and loads the register defaults. When the
// receiver stalls, each full stage holds as long as the one after it holds, so
// bubbles are squeezed out and s_axis_tready drops only once every stage
// holds a pixel; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hsv_pixel_recolor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
    input  logic        cfg_we,
    input  logic [hpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hpr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hpr_pkg::*;

    // Configuration registers.
    logic        mode_reg;
    logic [23:0] target_reg, reference_reg;
    logic [15:0] sat_gain_reg, val_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            target_reg    <= 24'hFFFFFF;
            reference_reg <= 24'hFFFFFF;
            sat_gain_reg  <= 16'd256;
            val_gain_reg  <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[0];
                REG_TARGET:    target_reg    <= cfg_data[23:0];
                REG_REFERENCE: reference_reg <= cfg_data[23:0];
                REG_SAT_GAIN:  sat_gain_reg  <= cfg_data[15:0];
                REG_VAL_GAIN:  val_gain_reg  <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // Stage valid bits and the stall chain: a stage loads when it is empty
    // or when the stage after it loads too.
    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] en;

    always_comb
    begin
        en[N_STAGES-1] = !vld_reg[N_STAGES-1] || m_axis_tready;
        for (int i = N_STAGES - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < N_STAGES; i++)
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // A fully zero pixel comes out of the datapath as zero color anyway;
    // only its alpha differs, so a single flag travels beside the data.
    logic [N_STAGES-1:0] zero_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
            zero_reg[0] <= (s_axis_tdata == 32'h0);
        for (int i = 1; i < N_STAGES; i++)
            if (en[i])
                zero_reg[i] <= zero_reg[i-1];
    end

    logic [15:0] pix_hue, tgt_hue, ref_hue;
    logic [16:0] pix_sat, pix_val;

    hpr_hsv_conv u_conv_pix (
        .clk   (clk),
        .en    (en[CONV_STAGES-1:0]),
        .red   (s_axis_tdata[7:0]),
        .green (s_axis_tdata[15:8]),
        .blue  (s_axis_tdata[23:16]),
        .hue   (pix_hue),
        .sat   (pix_sat),
        .val   (pix_val)
    );

    hpr_hsv_conv u_conv_tgt (
        .clk   (clk),
        .en    (en[CONV_STAGES-1:0]),
        .red   (target_reg[23:16]),
        .green (target_reg[15:8]),
        .blue  (target_reg[7:0]),
        .hue   (tgt_hue),
        .sat   (),
        .val   ()
    );

    hpr_hsv_conv u_conv_ref (
        .clk   (clk),
        .en    (en[CONV_STAGES-1:0]),
        .red   (reference_reg[23:16]),
        .green (reference_reg[15:8]),
        .blue  (reference_reg[7:0]),
        .hue   (ref_hue),
        .sat   (),
        .val   ()
    );

    logic [7:0] red_o, green_o, blue_o;

    hpr_hsv_back u_back (
        .clk             (clk),
        .en              (en[N_STAGES-1:CONV_STAGES]),
        .mode            (mode_reg),
        .saturation_gain (sat_gain_reg),
        .value_gain      (val_gain_reg),
        .target_hue      (tgt_hue),
        .reference_hue   (ref_hue),
        .hue             (pix_hue),
        .sat             (pix_sat),
        .val             (pix_val),
        .red             (red_o),
        .green           (green_o),
        .blue            (blue_o)
    );

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[N_STAGES-1];
    assign m_axis_tdata  = {(zero_reg[N_STAGES-1] ? 8'd0 : 8'd255), blue_o, green_o, red_o};

endmodule
